// ----- hw/rtl/rrps_pkg.sv -----
// Shared widths, constants and types of the radial ring pulse shader.
package rrps_pkg;

    // Distance and radius values are unsigned Q10.6.
    localparam int DIST_W  = 16;
    // Brightness level width.
    localparam int LEVEL_W = 8;
    // Rounded level numerator 2*c*peak + half_band, and denominator 2*half_band.
    localparam int NUM_W   = 2 * DIST_W + 1 - LEVEL_W + 2 * LEVEL_W - LEVEL_W + 1;
    localparam int DEN_W   = DIST_W + 1;
    // Quotient bit counter of the divider.
    localparam int CNT_W   = $clog2(LEVEL_W);

    // Result of the serial divider, valid for one cycle when done is high.
    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] quotient;
    } rrps_div_res_t;

endpackage

// ----- hw/rtl/rrps_div.sv -----
// Restoring divider that finds one quotient bit per cycle.
module rrps_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [rrps_pkg::NUM_W-1:0] num,
    input  logic [rrps_pkg::DEN_W-1:0] den,
    output rrps_pkg::rrps_div_res_t    res
);
    import rrps_pkg::*;

    logic [NUM_W-1:0]   rem_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [LEVEL_W-1:0] q_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [NUM_W-1:0]   trial;
    logic               fits;

    // Divisor aligned to the quotient bit under test.
    always_comb begin
        trial = NUM_W'(den_reg) << cnt_reg;
        fits  = (rem_reg >= trial);
    end

    // Iteration from the top quotient bit down to bit zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= num;
                den_reg  <= den;
                cnt_reg  <= CNT_W'(LEVEL_W - 1);
                q_reg    <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (fits) begin
                    rem_reg <= rem_reg - trial;
                end
                q_reg[cnt_reg] <= fits;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign res.done     = done_reg;
    assign res.quotient = q_reg;

endmodule

// ----- hw/rtl/radial_ring_pulse_shader.sv -----
// Top level of the radial ring pulse shader: ring state, sequencer and output stage.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_tvalid / s_tready  tuser: op; tdata: spawn, led_distance
//   m_        out        m_tvalid / m_tready  tdata: red, green, blue
//   cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A tick request visits the rings one per cycle.
// A pixel request lit by a ring runs a closeness scan that visits one ring per cycle,
// one multiply, and the eight-step serial divider for rounding;
// an unlit pixel skips the divider.
// s_tready is high only while the sequencer is idle; a finished result waits in
// the output register, so a new request is taken while m_tready is low.
// aresetn clears all rings, the registers to their defaults and the output valid.
module radial_ring_pulse_shader #(
    parameter int RINGS = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input requests.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [0:0]  s_tuser,   // [0] op
    input  logic [23:0] s_tdata,   // [0] spawn, [16:1] led_distance, [23:17] zero
    // Results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    // Register writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import rrps_pkg::*;

    localparam int RING_W = (RINGS > 1) ? $clog2(RINGS) : 1;

    localparam logic [7:0] REG_EXTENT      = 8'd0;
    localparam logic [7:0] REG_GROWTH_STEP = 8'd1;
    localparam logic [7:0] REG_HALF_BAND   = 8'd2;
    localparam logic [7:0] REG_PEAK_LEVEL  = 8'd3;

    // floor(v * 88 / 100) = (v * 230692) >> 18 for every 8-bit v.
    localparam int          GREEN_SHIFT = 18;
    localparam int          GREEN_W     = LEVEL_W + GREEN_SHIFT;
    localparam logic [17:0] GREEN_MUL   = 18'd230692;
    localparam int          RED_W       = LEVEL_W + 2;
    localparam int          PROD_W      = DIST_W + LEVEL_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_PIX,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_COLOR
    } state_t;

    state_t               state_reg,      state_next;
    logic [RING_W-1:0]    ring_idx_reg,   ring_idx_next;
    logic                 spawn_pend_reg, spawn_pend_next;
    logic [DIST_W-1:0]    led_dist_reg,   led_dist_next;
    logic [DIST_W-1:0]    best_reg,       best_next;
    logic [PROD_W-1:0]    prod_reg,       prod_next;
    logic [LEVEL_W-1:0]   level_reg,      level_next;
    logic [RINGS-1:0]     ring_active_reg, ring_active_next;
    logic [DIST_W-1:0]    ring_radius_reg [RINGS];
    logic [DIST_W-1:0]    ring_radius_next [RINGS];
    logic [DIST_W-1:0]    extent_reg,     extent_next;
    logic [DIST_W-1:0]    step_reg,       step_next;
    logic [DIST_W-1:0]    half_band_reg,  half_band_next;
    logic [LEVEL_W-1:0]   peak_reg,       peak_next;
    logic                 m_tvalid_reg,   m_tvalid_next;
    logic [LEVEL_W-1:0]   red_reg,        red_next;
    logic [LEVEL_W-1:0]   green_reg,      green_next;
    logic [LEVEL_W-1:0]   blue_reg,       blue_next;

    logic                 cur_act;
    logic [DIST_W-1:0]    cur_rad;
    logic                 last_ring;
    logic                 take_slot;
    logic [DIST_W-1:0]    base_rad;
    logic [DIST_W:0]      rad_sum;
    logic [DIST_W-1:0]    rad_sat;
    logic [DIST_W:0]      retire_limit;
    logic [DIST_W-1:0]    ring_diff;
    logic                 in_band;
    logic [DIST_W-1:0]    closeness;
    logic [RED_W-1:0]     red_prod;
    logic [GREEN_W-1:0]   green_prod;
    logic                 out_free;
    logic                 div_start;
    logic [NUM_W-1:0]     div_num;
    logic [DEN_W-1:0]     div_den;
    rrps_div_res_t        div_res;

    // Rounded level divider.
    rrps_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .res     (div_res)
    );

    assign div_start = (state_reg == ST_DIV_GO);
    assign div_num   = NUM_W'({prod_reg, 1'b0}) + NUM_W'(half_band_reg);
    assign div_den   = {half_band_reg, 1'b0};

    // Ring currently visited by the sequencer.
    always_comb begin
        cur_act      = ring_active_reg[ring_idx_reg];
        cur_rad      = ring_radius_reg[ring_idx_reg];
        last_ring    = (ring_idx_reg == RING_W'(RINGS - 1));
        // Tick: a spawn goes to the first free slot, then every live ring grows.
        take_slot    = spawn_pend_reg && !cur_act;
        base_rad     = cur_act ? cur_rad : '0;
        rad_sum      = {1'b0, base_rad} + {1'b0, step_reg};
        rad_sat      = rad_sum[DIST_W] ? '1 : rad_sum[DIST_W-1:0];
        retire_limit = {1'b0, extent_reg} + {1'b0, half_band_reg};
        // Pixel: closeness to the visited ring.
        ring_diff    = (led_dist_reg >= cur_rad) ? (led_dist_reg - cur_rad)
                                                 : (cur_rad - led_dist_reg);
        in_band      = cur_act && (ring_diff < half_band_reg);
        closeness    = half_band_reg - ring_diff;
        // Color split of the level.
        red_prod     = RED_W'(level_reg) * RED_W'(3);
        green_prod   = GREEN_W'(level_reg) * GREEN_W'(GREEN_MUL);
        out_free     = !m_tvalid_reg || m_tready;
    end

    // Sequencer, ring state, registers and output stage.
    always_comb begin
        state_next       = state_reg;
        ring_idx_next    = ring_idx_reg;
        spawn_pend_next  = spawn_pend_reg;
        led_dist_next    = led_dist_reg;
        best_next        = best_reg;
        prod_next        = prod_reg;
        level_next       = level_reg;
        ring_active_next = ring_active_reg;
        ring_radius_next = ring_radius_reg;
        extent_next      = extent_reg;
        step_next        = step_reg;
        half_band_next   = half_band_reg;
        peak_next        = peak_reg;
        m_tvalid_next    = m_tvalid_reg;
        red_next         = red_reg;
        green_next       = green_reg;
        blue_next        = blue_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // Register writes; unknown indexes are dropped.
        if (cfg_valid) begin
            case (cfg_index)
                REG_EXTENT:      extent_next    = cfg_data;
                REG_GROWTH_STEP: step_next      = cfg_data;
                REG_HALF_BAND:   half_band_next = cfg_data;
                REG_PEAK_LEVEL:  peak_next      = cfg_data[LEVEL_W-1:0];
                default:         ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ring_idx_next   = '0;
                    best_next       = '0;
                    led_dist_next   = s_tdata[DIST_W:1];
                    spawn_pend_next = s_tdata[0] && !s_tuser[0];
                    state_next      = s_tuser[0] ? ST_PIX : ST_TICK;
                end
            end
            ST_TICK: begin
                if (cur_act || take_slot) begin
                    ring_radius_next[ring_idx_reg] = rad_sat;
                    ring_active_next[ring_idx_reg] = ({1'b0, rad_sat} <= retire_limit);
                end
                if (take_slot) begin
                    spawn_pend_next = 1'b0;
                end
                if (last_ring) begin
                    state_next = ST_IDLE;
                end else begin
                    ring_idx_next = ring_idx_reg + 1'b1;
                end
            end
            ST_PIX: begin
                if (in_band && (closeness > best_reg)) begin
                    best_next = closeness;
                end
                if (last_ring) begin
                    state_next = ST_MUL;
                end else begin
                    ring_idx_next = ring_idx_reg + 1'b1;
                end
            end
            ST_MUL: begin
                // No lit ring (also covers a zero half band) gives level zero.
                if (best_reg == '0) begin
                    level_next = '0;
                    state_next = ST_COLOR;
                end else begin
                    prod_next  = PROD_W'(best_reg) * PROD_W'(peak_reg);
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO: begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_res.done) begin
                    level_next = div_res.quotient;
                    state_next = ST_COLOR;
                end
            end
            ST_COLOR: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    red_next      = red_prod[RED_W-1:2];
                    green_next    = green_prod[GREEN_W-1:GREEN_SHIFT];
                    blue_next     = level_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            ring_active_reg <= '0;
            m_tvalid_reg    <= 1'b0;
            extent_reg      <= 16'd21760;
            step_reg        <= 16'd198;
            half_band_reg   <= 16'd1088;
            peak_reg        <= 8'd204;
            spawn_pend_reg  <= 1'b0;
            ring_idx_reg    <= '0;
        end else begin
            state_reg       <= state_next;
            ring_active_reg <= ring_active_next;
            m_tvalid_reg    <= m_tvalid_next;
            extent_reg      <= extent_next;
            step_reg        <= step_next;
            half_band_reg   <= half_band_next;
            peak_reg        <= peak_next;
            spawn_pend_reg  <= spawn_pend_next;
            ring_idx_reg    <= ring_idx_next;
            led_dist_reg    <= led_dist_next;
            best_reg        <= best_next;
            prod_reg        <= prod_next;
            level_reg       <= level_next;
            ring_radius_reg <= ring_radius_next;
            red_reg         <= red_next;
            green_reg       <= green_next;
            blue_reg        <= blue_next;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {blue_reg, green_reg, red_reg};

    // A result appears only from the color stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_COLOR))
        else $error("result raised outside the color stage");

    // The divider finishes only while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished while not awaited");

    // A tick starts at most one ring.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |->
            ($countones(ring_active_reg) <= $countones($past(ring_active_reg)) + 1))
        else $error("more than one ring started at once");

    // Rings change only during a tick.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $past(state_reg != ST_TICK)) |-> $stable(ring_active_reg))
        else $error("ring flags changed outside a tick");

endmodule
